>>> design/wepid_pkg.sv
// Package: types, constants and register codes for the wrapped-error PID controller.
package wepid_pkg;

   localparam int AccW      = 64;
   localparam int IntegW    = 48;
   localparam int ErrW      = 18;
   localparam int DiffW     = 19;
   localparam int MagW      = 17;
   localparam int FracW     = 24;
   localparam int QuotW     = MagW + FracW;
   localparam int PeriodW   = 24;
   localparam int GainW     = 16;
   localparam int LimitW    = 15;
   localparam int DataW     = 16;
   localparam int OutFracW  = 8;
   localparam int CntW      = 6;
   localparam int CsrIdxW   = 3;
   localparam int CsrDataW  = 24;

   localparam int MulLongSteps = PeriodW;
   localparam int MulGainSteps = GainW;
   localparam int DivSteps     = QuotW;

   localparam int FoldLimit = 4092;
   localparam int FoldSpan  = 8191;

   localparam logic [IntegW-1:0] IntegMax = {1'b0, {(IntegW-1){1'b1}}};
   localparam logic [IntegW-1:0] IntegMin = {1'b1, {(IntegW-1){1'b0}}};

   localparam logic [GainW-1:0]   PropGainRst     = GainW'(256);
   localparam logic [GainW-1:0]   IntegGainRst    = '0;
   localparam logic [GainW-1:0]   DerivGainRst    = '0;
   localparam logic [PeriodW-1:0] SamplePeriodRst = PeriodW'(16777);
   localparam logic [LimitW-1:0]  OutputLimitRst  = LimitW'(15000);
   localparam logic               WrapEnableRst   = 1'b0;

   localparam logic [CsrIdxW-1:0] RegPropGain     = CsrIdxW'(0);
   localparam logic [CsrIdxW-1:0] RegIntegGain    = CsrIdxW'(1);
   localparam logic [CsrIdxW-1:0] RegDerivGain    = CsrIdxW'(2);
   localparam logic [CsrIdxW-1:0] RegSamplePeriod = CsrIdxW'(3);
   localparam logic [CsrIdxW-1:0] RegOutputLimit  = CsrIdxW'(4);
   localparam logic [CsrIdxW-1:0] RegWrapEnable   = CsrIdxW'(5);

   typedef struct packed {
      logic signed [DataW-1:0] measured;
      logic signed [DataW-1:0] target;
   } req_type;

   typedef struct packed {
      logic signed [DataW-1:0] drive;
      logic                    clipped;
   } rsp_type;

   typedef struct packed {
      logic [GainW-1:0]   prop_gain;
      logic [GainW-1:0]   integ_gain;
      logic [GainW-1:0]   deriv_gain;
      logic [PeriodW-1:0] sample_period;
      logic [LimitW-1:0]  output_limit;
      logic               wrap_enable;
   } cfg_type;

   typedef struct packed {
      logic [AccW-1:0] a;
      logic [AccW-1:0] b;
      logic            sub;
   } alu_req_type;

   typedef struct packed {
      logic idle;
      logic done;
   } core_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_SAT,
      ST_ACC,
      ST_ROUND,
      ST_DSETUP,
      ST_DIV,
      ST_DNEG,
      ST_FINAL,
      ST_CLAMP
   } seq_state_type;

   typedef enum logic [1:0] {
      PH_INT,
      PH_PROP,
      PH_INTEG,
      PH_DERIV
   } phase_type;

endpackage

>>> design/wepid_csr.sv
// Configuration register file for the wrapped-error PID controller.
module wepid_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [wepid_pkg::CsrIdxW-1:0]    wr_index,
   input  logic [wepid_pkg::CsrDataW-1:0]   wr_data,
   output wepid_pkg::cfg_type               cfg
);
   import wepid_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            RegPropGain:     cfg_in.prop_gain     = wr_data[GainW-1:0];
            RegIntegGain:    cfg_in.integ_gain    = wr_data[GainW-1:0];
            RegDerivGain:    cfg_in.deriv_gain    = wr_data[GainW-1:0];
            RegSamplePeriod: cfg_in.sample_period = wr_data[PeriodW-1:0];
            RegOutputLimit:  cfg_in.output_limit  = wr_data[LimitW-1:0];
            RegWrapEnable:   cfg_in.wrap_enable   = wr_data[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain     <= PropGainRst;
         cfg_ff.integ_gain    <= IntegGainRst;
         cfg_ff.deriv_gain    <= DerivGainRst;
         cfg_ff.sample_period <= SamplePeriodRst;
         cfg_ff.output_limit  <= OutputLimitRst;
         cfg_ff.wrap_enable   <= WrapEnableRst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> design/wepid_alu.sv
// Shared 64-bit adder/subtractor used by the sequencer's arithmetic steps.
module wepid_alu (
   input  wepid_pkg::alu_req_type           req,
   output logic [wepid_pkg::AccW-1:0]       sum
);
   import wepid_pkg::*;

   always_comb begin
      if (req.sub) begin
         sum = req.a - req.b;
      end else begin
         sum = req.a + req.b;
      end
   end

endmodule

>>> design/wepid_seq.sv
// Sequencer and datapath registers: multiply, divide, saturate and round on the shared adder, then clamp.
module wepid_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  wepid_pkg::req_type            req,
   input  wepid_pkg::cfg_type            cfg,
   input  logic                          res_free,
   output wepid_pkg::core_stat_type      stat,
   output wepid_pkg::rsp_type            rsp,
   output wepid_pkg::alu_req_type        alu_req,
   input  logic [wepid_pkg::AccW-1:0]    alu_sum
);
   import wepid_pkg::*;

   seq_state_type state_ff, state_in;
   phase_type     phase_ff, phase_in;

   logic [IntegW-1:0]  integ_ff, integ_in;
   logic [ErrW-1:0]    prev_ff, prev_in;
   logic [ErrW-1:0]    err_ff, err_in;
   logic [AccW-1:0]    acc_ff, acc_in;
   logic [AccW-1:0]    total_ff, total_in;
   logic [AccW-1:0]    mcand_ff, mcand_in;
   logic [PeriodW-1:0] mplier_ff, mplier_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic [PeriodW-1:0] rem_ff, rem_in;
   logic [QuotW-1:0]   quot_ff, quot_in;
   logic               neg_ff, neg_in;

   logic signed [ErrW-1:0]  raw_err, fold_lo, fold_err;
   logic signed [DiffW-1:0] err_diff;
   logic [DiffW-1:0]        diff_mag;
   logic [PeriodW-1:0]      per_eff;
   logic [PeriodW:0]        rem_shift;
   logic                    integ_fits;
   logic signed [AccW-1:0]  value, lim_pos, lim_neg;
   logic                    over, under;

   // error and its fold
   always_comb begin
      raw_err = {{(ErrW-DataW){req.target[DataW-1]}}, req.target}
              - {{(ErrW-DataW){req.measured[DataW-1]}}, req.measured};
      fold_lo = raw_err;
      if (cfg.wrap_enable && (raw_err < -FoldLimit)) begin
         fold_lo = raw_err + ErrW'(FoldSpan);
      end
      fold_err = fold_lo;
      if (cfg.wrap_enable && (fold_lo > FoldLimit)) begin
         fold_err = fold_lo - ErrW'(FoldSpan);
      end
   end

   assign err_diff = {err_ff[ErrW-1], err_ff} - {prev_ff[ErrW-1], prev_ff};
   assign diff_mag = err_diff[DiffW-1] ? -err_diff : err_diff;
   assign per_eff  = (cfg.sample_period == '0) ? PeriodW'(1) : cfg.sample_period;
   assign rem_shift = {rem_ff, quot_ff[QuotW-1]};
   assign integ_fits = (&alu_sum[AccW-1:IntegW-1]) | ~(|alu_sum[AccW-1:IntegW-1]);

   assign value   = acc_ff;
   assign lim_pos = {{(AccW-LimitW){1'b0}}, cfg.output_limit};
   assign lim_neg = -lim_pos;
   assign over    = value > lim_pos;
   assign under   = value < lim_neg;

   // shared adder operands
   always_comb begin
      alu_req.a   = '0;
      alu_req.b   = '0;
      alu_req.sub = 1'b0;
      case (state_ff)
         ST_MUL: begin
            alu_req.a = {acc_ff[AccW-2:0], 1'b0};
            alu_req.b = mplier_ff[PeriodW-1] ? mcand_ff : '0;
         end
         ST_SAT: begin
            alu_req.a = acc_ff;
            alu_req.b = {{(AccW-IntegW){integ_ff[IntegW-1]}}, integ_ff};
         end
         ST_ACC: begin
            alu_req.a = total_ff;
            alu_req.b = acc_ff;
         end
         ST_ROUND: begin
            alu_req.a = acc_ff;
            alu_req.b = acc_ff[AccW-1] ? {{(AccW-FracW){1'b0}}, {FracW{1'b1}}} : '0;
         end
         ST_DIV: begin
            alu_req.a   = {{(AccW-PeriodW-1){1'b0}}, rem_shift};
            alu_req.b   = {{(AccW-PeriodW){1'b0}}, per_eff};
            alu_req.sub = 1'b1;
         end
         ST_DNEG: begin
            alu_req.b   = {{(AccW-QuotW){1'b0}}, quot_ff};
            alu_req.sub = neg_ff;
         end
         ST_FINAL: begin
            alu_req.a = total_ff;
            alu_req.b = total_ff[AccW-1] ?
                        {{(AccW-OutFracW){1'b0}}, {OutFracW{1'b1}}} : '0;
         end
         default: begin
            alu_req.a = '0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_MUL;
               phase_in = PH_INT;
            end
         end
         ST_MUL: begin
            if (cnt_ff == '0) begin
               case (phase_ff)
                  PH_INT:   state_in = ST_SAT;
                  PH_INTEG: state_in = ST_ROUND;
                  default:  state_in = ST_ACC;
               endcase
            end
         end
         ST_SAT: begin
            state_in = ST_MUL;
            phase_in = PH_PROP;
         end
         ST_ACC: begin
            case (phase_ff)
               PH_PROP: begin
                  state_in = ST_MUL;
                  phase_in = PH_INTEG;
               end
               PH_INTEG: state_in = ST_DSETUP;
               default:  state_in = ST_FINAL;
            endcase
         end
         ST_ROUND:  state_in = ST_ACC;
         ST_DSETUP: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_DNEG;
            end
         end
         ST_DNEG: begin
            state_in = ST_MUL;
            phase_in = PH_DERIV;
         end
         ST_FINAL: state_in = ST_CLAMP;
         ST_CLAMP: begin
            if (res_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      integ_in  = integ_ff;
      prev_in   = prev_ff;
      err_in    = err_ff;
      acc_in    = acc_ff;
      total_in  = total_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      neg_in    = neg_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               err_in    = fold_err;
               acc_in    = '0;
               total_in  = '0;
               mcand_in  = {{(AccW-ErrW){fold_err[ErrW-1]}}, fold_err};
               mplier_in = cfg.sample_period;
               cnt_in    = CntW'(MulLongSteps - 1);
            end
         end
         ST_MUL: begin
            acc_in    = alu_sum;
            mplier_in = {mplier_ff[PeriodW-2:0], 1'b0};
            cnt_in    = cnt_ff - 1'b1;
         end
         ST_SAT: begin
            if (integ_fits) begin
               integ_in = alu_sum[IntegW-1:0];
            end else begin
               integ_in = alu_sum[AccW-1] ? IntegMin : IntegMax;
            end
            acc_in    = '0;
            mcand_in  = {{(AccW-ErrW){err_ff[ErrW-1]}}, err_ff};
            mplier_in = {cfg.prop_gain, {(PeriodW-GainW){1'b0}}};
            cnt_in    = CntW'(MulGainSteps - 1);
         end
         ST_ACC: begin
            total_in = alu_sum;
            if (phase_ff == PH_PROP) begin
               acc_in    = '0;
               mcand_in  = {{(AccW-IntegW){integ_ff[IntegW-1]}}, integ_ff};
               mplier_in = {cfg.integ_gain, {(PeriodW-GainW){1'b0}}};
               cnt_in    = CntW'(MulGainSteps - 1);
            end
         end
         ST_ROUND: begin
            acc_in = {{FracW{alu_sum[AccW-1]}}, alu_sum[AccW-1:FracW]};
         end
         ST_DSETUP: begin
            neg_in  = err_diff[DiffW-1];
            quot_in = {diff_mag[MagW-1:0], {FracW{1'b0}}};
            rem_in  = '0;
            cnt_in  = CntW'(DivSteps - 1);
            prev_in = err_ff;
         end
         ST_DIV: begin
            if (!alu_sum[AccW-1]) begin
               rem_in  = alu_sum[PeriodW-1:0];
               quot_in = {quot_ff[QuotW-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift[PeriodW-1:0];
               quot_in = {quot_ff[QuotW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
         end
         ST_DNEG: begin
            mcand_in  = alu_sum;
            acc_in    = '0;
            mplier_in = {cfg.deriv_gain, {(PeriodW-GainW){1'b0}}};
            cnt_in    = CntW'(MulGainSteps - 1);
         end
         ST_FINAL: begin
            acc_in = {{OutFracW{alu_sum[AccW-1]}}, alu_sum[AccW-1:OutFracW]};
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   // outputs
   always_comb begin
      stat.idle   = (state_ff == ST_IDLE);
      stat.done   = (state_ff == ST_CLAMP);
      rsp.clipped = over | under;
      if (over) begin
         rsp.drive = lim_pos[DataW-1:0];
      end else if (under) begin
         rsp.drive = lim_neg[DataW-1:0];
      end else begin
         rsp.drive = value[DataW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_INT;
         integ_ff <= '0;
         prev_ff  <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         integ_ff <= integ_in;
         prev_ff  <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff    <= err_in;
      acc_ff    <= acc_in;
      total_ff  <= total_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
      rem_ff    <= rem_in;
      quot_ff   <= quot_in;
      neg_ff    <= neg_in;
   end

endmodule

>>> design/wrapped_error_pid_controller_core.sv
// Top level of the wrapped-error PID controller: handshakes, result register, assertions.
//
//   channel  dir  handshake             beat
//   req_     in   req_valid/req_stall   measured, target
//   rsp_     out  rsp_valid/rsp_stall   drive, clipped
//   csr_     in   csr_valid/csr_ready   csr_index, csr_wdata
//
// A beat runs through the sequencer in steps: a 24-step period multiply, three
// 16-step gain multiplies, a 41-step restoring divide and nine single steps, the
// arithmetic on one 64-bit adder; the result register loads in the last step.
// req_stall stays high from the accept until the sequencer is back in idle.
// A result waiting under rsp_stall holds the sequencer in its clamp step.
// Synchronous active-high reset clears integral and last error.
module wrapped_error_pid_controller_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  wepid_pkg::req_type               req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output wepid_pkg::rsp_type               rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [wepid_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [wepid_pkg::CsrDataW-1:0]   csr_wdata
);
   import wepid_pkg::*;

   cfg_type       cfg;
   core_stat_type stat;
   rsp_type       core_rsp;
   alu_req_type   alu_req;
   logic [AccW-1:0] alu_sum;

   logic    start, res_free, load;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_payload_ff;

   assign csr_ready = 1'b1;
   assign req_stall = !stat.idle;
   assign start     = req_valid && !req_stall;
   assign res_free  = !rsp_valid_ff || !rsp_stall;
   assign load      = stat.done && res_free;

   wepid_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   wepid_alu u_alu (
      .req (alu_req),
      .sum (alu_sum)
   );

   wepid_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req_payload),
      .cfg      (cfg),
      .res_free (res_free),
      .stat     (stat),
      .rsp      (core_rsp),
      .alu_req  (alu_req),
      .alu_sum  (alu_sum)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_payload_ff <= core_rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !stat.idle)
      else $error("sequencer idle after accepting a beat");

   a_drive_in_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (($signed(rsp_payload.drive) <= $signed({1'b0, cfg.output_limit}))
                 && ($signed(rsp_payload.drive) >= -$signed({1'b0, cfg.output_limit}))))
      else $error("drive outside output limit");

   a_clip_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.clipped) |->
         (($signed(rsp_payload.drive) == $signed({1'b0, cfg.output_limit}))
       || ($signed(rsp_payload.drive) == -$signed({1'b0, cfg.output_limit}))))
      else $error("clipped drive not at the limit");
`endif

endmodule

>>> dv/wrapped_error_pid_controller_core_tb.sv
// Testbench for the wrapped-error PID controller: directed table, then random phases.
module wrapped_error_pid_controller_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wepid_pkg::*;

   localparam int RandomBeats = 400;
   localparam int WindupBeats = 140;
   localparam int SettleCycles = 200;
   localparam int DrainLimit = 20000;
   localparam longint IntegTop = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint IntegBottom = -IntegTop - 1;

   typedef enum bit [1:0] {ROW_REG, ROW_BEAT, ROW_KNOWN} row_kind_type;

   typedef struct {
      row_kind_type kind;
      int           sel;
      int           arg;
      int           measured;
      int           target;
      int           drive;
      bit           clipped;
   } plan_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_payload;
   logic csr_valid;
   logic csr_ready;
   logic [CsrIdxW-1:0] csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   cfg_type ctl_cfg;
   longint integ_acc;
   longint last_err;
   rsp_type drive_due[$];
   int fault_count;
   bit no_gaps;

   plan_row_type opening_plan [0:33] = '{
      '{ROW_KNOWN, 0, 0, 0, 0, 0, 1'b0},
      '{ROW_KNOWN, 0, 0, 0, 100, 100, 1'b0},
      '{ROW_KNOWN, 0, 0, -32768, 32767, 15000, 1'b1},
      '{ROW_KNOWN, 0, 0, 32767, -32768, -15000, 1'b1},
      '{ROW_KNOWN, 0, 0, 0, 15000, 15000, 1'b0},
      '{ROW_KNOWN, 0, 0, 0, 15001, 15000, 1'b1},
      '{ROW_KNOWN, 0, 0, 0, -15001, -15000, 1'b1},
      '{ROW_KNOWN, 0, 0, -1, -1, 0, 1'b0},
      '{ROW_REG, RegWrapEnable, 1, 0, 0, 0, 1'b0},
      '{ROW_BEAT, 0, 0, 0, 4092, 0, 1'b0},
      '{ROW_BEAT, 0, 0, 0, 4093, 0, 1'b0},
      '{ROW_BEAT, 0, 0, 0, -4093, 0, 1'b0},
      '{ROW_BEAT, 0, 0, 0, -4092, 0, 1'b0},
      '{ROW_BEAT, 0, 0, -32768, 32767, 0, 1'b0},
      '{ROW_BEAT, 0, 0, 32767, -32768, 0, 1'b0},
      '{ROW_REG, RegOutputLimit, 0, 0, 0, 0, 1'b0},
      '{ROW_KNOWN, 0, 0, 0, 100, 0, 1'b1},
      '{ROW_KNOWN, 0, 0, 5, 5, 0, 1'b0},
      '{ROW_REG, RegWrapEnable, 0, 0, 0, 0, 1'b0},
      '{ROW_REG, RegOutputLimit, 32767, 0, 0, 0, 1'b0},
      '{ROW_REG, RegIntegGain, 65535, 0, 0, 0, 1'b0},
      '{ROW_REG, RegDerivGain, 65535, 0, 0, 0, 1'b0},
      '{ROW_REG, RegSamplePeriod, 0, 0, 0, 0, 1'b0},
      '{ROW_BEAT, 0, 0, 0, 1, 0, 1'b0},
      '{ROW_BEAT, 0, 0, -32768, 32767, 0, 1'b0},
      '{ROW_BEAT, 0, 0, 32767, -32768, 0, 1'b0},
      '{ROW_REG, RegSamplePeriod, 16777215, 0, 0, 0, 1'b0},
      '{ROW_REG, RegPropGain, 65535, 0, 0, 0, 1'b0},
      '{ROW_BEAT, 0, 0, -32768, 32767, 0, 1'b0},
      '{ROW_BEAT, 0, 0, 32767, -32768, 0, 1'b0},
      '{ROW_REG, RegPropGain, 0, 0, 0, 0, 1'b0},
      '{ROW_REG, RegIntegGain, 0, 0, 0, 0, 1'b0},
      '{ROW_REG, RegDerivGain, 0, 0, 0, 0, 1'b0},
      '{ROW_KNOWN, 0, 0, 123, -4567, 0, 1'b0}
   };

   wrapped_error_pid_controller_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic rsp_type predict_drive(input req_type beat);
      longint err;
      longint span;
      longint rate;
      longint p_t;
      longint i_t;
      longint d_t;
      longint value;
      longint lim;
      rsp_type res;
      err = longint'($signed(beat.target)) - longint'($signed(beat.measured));
      if (ctl_cfg.wrap_enable) begin
         if (err < -FoldLimit) err += FoldSpan;
         if (err > FoldLimit) err -= FoldSpan;
      end
      integ_acc += err * longint'(ctl_cfg.sample_period);
      if (integ_acc > IntegTop) integ_acc = IntegTop;
      if (integ_acc < IntegBottom) integ_acc = IntegBottom;
      span = (ctl_cfg.sample_period == 0) ? 1 : longint'(ctl_cfg.sample_period);
      rate = ((err - last_err) * (longint'(1) << FracW)) / span;
      p_t = longint'(ctl_cfg.prop_gain) * err;
      i_t = (longint'(ctl_cfg.integ_gain) * integ_acc) / (longint'(1) << FracW);
      d_t = longint'(ctl_cfg.deriv_gain) * rate;
      value = (p_t + i_t + d_t) / 256;
      last_err = err;
      lim = longint'(ctl_cfg.output_limit);
      res.clipped = 1'b0;
      if (value > lim) begin
         value = lim;
         res.clipped = 1'b1;
      end
      if (value < -lim) begin
         value = -lim;
         res.clipped = 1'b1;
      end
      res.drive = DataW'(value);
      return res;
   endfunction

   function automatic void note_failure(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("%s", msg);
   endfunction

   function automatic int unsigned pick_value(input int unsigned bottom, input int unsigned top);
      int unsigned sel;
      sel = $urandom_range(3, 0);
      if (sel == 0) return bottom;
      if (sel == 1) return top;
      return $urandom_range(top, bottom);
   endfunction

   function automatic req_type draw_beat(input bit windup);
      req_type beat;
      int base;
      int delta;
      int unsigned mode;
      mode = $urandom_range(2, 0);
      if (windup) begin
         beat.measured = DataW'(-32768 + int'($urandom_range(60, 0)));
         beat.target = DataW'(32767 - int'($urandom_range(60, 0)));
      end else if (mode == 0) begin
         beat = req_type'($urandom);
      end else begin
         base = int'($urandom_range(40000, 0)) - 20000;
         if (mode == 1) delta = int'($urandom_range(16600, 0)) - 8300;
         else delta = int'($urandom_range(4100, 4085));
         if (mode == 2 && $urandom_range(1, 0) == 1) delta = -delta;
         beat.measured = DataW'(base);
         beat.target = DataW'(base + delta);
      end
      return beat;
   endfunction

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         RegPropGain:     ctl_cfg.prop_gain = data[GainW-1:0];
         RegIntegGain:    ctl_cfg.integ_gain = data[GainW-1:0];
         RegDerivGain:    ctl_cfg.deriv_gain = data[GainW-1:0];
         RegSamplePeriod: ctl_cfg.sample_period = data[PeriodW-1:0];
         RegOutputLimit:  ctl_cfg.output_limit = data[LimitW-1:0];
         RegWrapEnable:   ctl_cfg.wrap_enable = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // leaves valid high after the accepting edge; drain, or a next call that waits a gap, lowers it
   task automatic send_beat(input req_type beat, input bit known, input rsp_type want);
      int gap;
      rsp_type got;
      gap = no_gaps ? 0 : $urandom_range(6, 0);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload <= beat;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      got = predict_drive(beat);
      drive_due.push_back(known ? want : got);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (drive_due.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drive_due.size() == 0) begin
            note_failure($sformatf("unexpected beat: drive %0d clipped %0b",
                                   rsp_payload.drive, rsp_payload.clipped));
         end else begin
            want = drive_due.pop_front();
            if (rsp_payload.drive !== want.drive)
               note_failure($sformatf("drive mismatch: expected %0d got %0d",
                                      want.drive, rsp_payload.drive));
            if (rsp_payload.clipped !== want.clipped)
               note_failure($sformatf("clipped mismatch: expected %0b got %0b",
                                      want.clipped, rsp_payload.clipped));
         end
      end
   end

   initial begin : rsp_side
      int hold;
      int seen;
      rsp_stall = 1'b0;
      forever begin
         do @(posedge clock); while (!(!reset && rsp_valid && !rsp_stall));
         hold = no_gaps ? 0 : $urandom_range(6, 0);
         if (hold != 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            seen = 0;
            while (seen < hold) begin
               @(posedge clock);
               if (rsp_valid) seen++;
            end
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("wrapped_error_pid_controller_core test failed");
      $finish;
   end

   initial begin : stimulus
      plan_row_type row;
      req_type beat;
      rsp_type want;
      int beats_left;
      int phase_no;
      int count;
      bit windup;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      no_gaps = 1'b0;
      fault_count = 0;
      integ_acc = 0;
      last_err = 0;
      ctl_cfg = '{PropGainRst, IntegGainRst, DerivGainRst, SamplePeriodRst,
                  OutputLimitRst, WrapEnableRst};
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      foreach (opening_plan[i]) begin
         row = opening_plan[i];
         if (row.kind == ROW_REG) begin
            drain_results();
            write_reg(CsrIdxW'(row.sel), CsrDataW'(row.arg));
         end else begin
            beat.measured = DataW'(row.measured);
            beat.target = DataW'(row.target);
            want.drive = DataW'(row.drive);
            want.clipped = row.clipped;
            send_beat(beat, row.kind == ROW_KNOWN, want);
         end
      end

      // first random phase winds the integral up into saturation
      beats_left = RandomBeats;
      phase_no = 0;
      while (beats_left > 0) begin
         drain_results();
         windup = (phase_no == 0);
         no_gaps = !windup && ($urandom_range(3, 0) == 0);
         write_reg(RegPropGain, CsrDataW'(pick_value(0, 65535)));
         write_reg(RegIntegGain, CsrDataW'(pick_value(0, 65535)));
         write_reg(RegDerivGain, CsrDataW'(pick_value(0, 65535)));
         write_reg(RegSamplePeriod, windup ? CsrDataW'(16777215)
                                           : CsrDataW'(pick_value(1, 16777215)));
         write_reg(RegOutputLimit, CsrDataW'(pick_value(0, 32767)));
         write_reg(RegWrapEnable, windup ? CsrDataW'(0) : CsrDataW'($urandom_range(1, 0)));
         count = windup ? WindupBeats : $urandom_range(50, 20);
         for (int k = 0; k < count && beats_left > 0; k++) begin
            send_beat(draw_beat(windup), 1'b0, want);
            beats_left--;
         end
         phase_no++;
      end

      drain_results();
      count = 0;
      while (drive_due.size() != 0 && count < DrainLimit) begin
         @(posedge clock);
         count++;
      end
      repeat (SettleCycles) @(posedge clock);
      if (drive_due.size() != 0)
         note_failure($sformatf("%0d results never arrived", drive_due.size()));
      if (fault_count == 0) begin
         $display("wrapped_error_pid_controller_core test passed");
      end else begin
         $display("wrapped_error_pid_controller_core test failed");
      end
      $finish;
   end

endmodule
